// File: rtl/msm_pkg.sv
package msm_pkg;

	localparam int VOICES        = 8;
	localparam int VOICE_BITS    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int MEM_ADDR_BITS = 16;
	localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
	localparam int OUTPUT_RATE   = 11025;
	localparam int DIV_BITS      = 32;
	localparam int STEP_W        = 19;
	localparam int STEP_MAX      = (1 << STEP_W) - 1;

	// rounded-up reciprocal of the output rate, exact floor for any 16-bit rate
	localparam int     STEP_SHIFT  = 32;
	localparam longint STEP_MUL    = ((longint'(1) << (16 + STEP_SHIFT)) +
		longint'(OUTPUT_RATE) - longint'(1)) / longint'(OUTPUT_RATE);
	localparam int     STEP_PROD_W = 16 + $clog2(STEP_MUL + 1);

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_START  = 3'd1,
		OP_STOP   = 3'd2,
		OP_VOLPAN = 3'd3,
		OP_MIX    = 3'd4,
		OP_QUERY  = 3'd5
	} msm_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MIX,
		ST_DRAIN,
		ST_WB,
		ST_DONE
	} msm_state_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [2:0]  voice;
		logic [15:0] mem_address;
		logic [7:0]  sample_byte;
		logic [15:0] play_length;
		logic [15:0] source_rate;
		logic [6:0]  volume;
		logic [7:0]  separation;
	} msm_in_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic               voice_playing;
		logic               start_accepted;
	} msm_out_t;

	typedef struct packed {
		logic        start;
		logic [15:0] rate;
	} msm_div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} msm_div_stat_t;

	// vol * sep / 255, exact for products below 65535
	function automatic logic [6:0] gain_of(logic [6:0] vol, logic [7:0] sep);
		logic [15:0] p;
		logic [15:0] q;
		p = 16'(vol) * 16'(sep);
		q = p + (p >> 8) + 16'd1;
		return q[14:8];
	endfunction

endpackage

// File: rtl/msm_div.sv
module msm_div
	import msm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  msm_div_ctrl_t       ctrl,
	output msm_div_stat_t       stat,
	output logic [DIV_BITS-1:0] quotient
);

	logic [15:0]            rate_q;
	logic [DIV_BITS-1:0]    quo_q;
	logic                   busy_q;
	logic                   done_q;
	logic [STEP_PROD_W-1:0] prod;

	// rate * 2^16 / OUTPUT_RATE by the reciprocal
	assign prod = STEP_PROD_W'(rate_q) * STEP_PROD_W'(STEP_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= ctrl.start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rate_q <= ctrl.rate;
		end
		if (busy_q) begin
			quo_q <= DIV_BITS'(prod >> STEP_SHIFT);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// File: rtl/multichannel_sample_mixer.sv
// Eight-voice stereo sample mixer with a 64 KiB byte sample memory that holds
// no defined value until written. Each beat on the item channel gives exactly
// one beat on the result channel. Sample writes, stop, volume/pan updates,
// queries, unused opcodes and zero-length starts go from idle straight to the
// done state. A mix frame takes the beat, then voices go through the
// single sample memory read port one per cycle, the drain and write-back
// states drain the accumulate stage and write back the sums, and the done
// state hands over the result. A start that plays registers the source rate,
// forms the step by one multiplication with the reciprocal of the output
// rate, and the result follows. A result still waiting on the result channel
// holds the block in its done state; otherwise a new item is taken while the
// previous result waits.
module multichannel_sample_mixer
	import msm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  msm_in_t  item,
	output logic     result_valid,
	input  logic     result_ready,
	output msm_out_t result
);

	msm_state_t state_q, state_d;

	logic [7:0]  mem [MEM_DEPTH];
	logic [7:0]  rd_s1;
	logic        hit_s1;
	logic [VOICE_BITS-1:0] vsel_s1;

	logic                  active_q [VOICES];
	logic [15:0]           base_q   [VOICES];
	logic [15:0]           len_q    [VOICES];
	logic [31:0]           pos_q    [VOICES];
	logic [STEP_W-1:0]     step_q   [VOICES];
	logic [6:0]            lgain_q  [VOICES];
	logic [6:0]            rgain_q  [VOICES];

	logic [VOICE_BITS-1:0] c_q;
	logic [VOICE_BITS-1:0] vidx;
	logic [VOICE_BITS-1:0] vstart_q;
	logic                  vok;
	logic                  accept;
	logic                  start_go;
	logic                  c_last;
	logic                  query_hit;

	msm_out_t res_q;
	msm_out_t result_q;
	logic     result_valid_q;
	logic signed [15:0] lsum_q, rsum_q;

	msm_div_ctrl_t         div_ctrl;
	msm_div_stat_t         div_stat;
	logic [DIV_BITS-1:0]   div_quo;

	logic [15:0]           idx;
	logic                  cur_act;
	logic                  hit;
	logic [31:0]           addr_sum;
	logic [32:0]           pos_next;
	logic [31:0]           waddr_w;
	logic [15:0]           rate_eff;

	logic signed [8:0]     smp;
	logic signed [16:0]    lprod, rprod;
	logic signed [15:0]    lterm, rterm;

	msm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign vidx      = VOICE_BITS'(item.voice);
	assign vok       = 32'(item.voice) < VOICES;
	assign accept    = item_valid && item_ready;
	assign start_go  = (item.opcode == OP_START) && vok && (item.play_length != 16'd0);
	assign c_last    = c_q == VOICE_BITS'(VOICES - 1);
	assign rate_eff  = (item.source_rate == 16'd0) ? 16'(OUTPUT_RATE) : item.source_rate;
	assign query_hit = (item.opcode == OP_QUERY) && vok && active_q[vidx];

	assign idx      = pos_q[c_q][31:16];
	assign cur_act  = active_q[c_q];
	assign hit      = (state_q == ST_MIX) && cur_act && (idx < len_q[c_q]);
	assign addr_sum = 32'(base_q[c_q]) + 32'(idx);
	assign pos_next = {1'b0, pos_q[c_q]} + 33'(step_q[c_q]);
	assign waddr_w  = 32'(item.mem_address);

	assign smp   = $signed({1'b0, rd_s1}) - 9'sd128;
	assign lprod = smp * $signed({1'b0, lgain_q[vsel_s1]});
	assign rprod = smp * $signed({1'b0, rgain_q[vsel_s1]});
	assign lterm = {lprod[14:0], 1'b0};
	assign rterm = {rprod[14:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		item_ready     = 1'b0;
		div_ctrl.start = 1'b0;
		div_ctrl.rate  = rate_eff;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item.opcode == OP_MIX) begin
						state_d = ST_MIX;
					end else if (start_go) begin
						state_d        = ST_DIV;
						div_ctrl.start = 1'b1;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_MIX: begin
				if (c_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_WB;
			ST_WB:    state_d = ST_DONE;
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sample memory
	always_ff @(posedge clk) begin
		if (accept && item.opcode == OP_WRITE) begin
			mem[waddr_w[MEM_ADDR_BITS-1:0]] <= item.sample_byte;
		end
		rd_s1 <= mem[addr_sum[MEM_ADDR_BITS-1:0]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				active_q[i] <= 1'b0;
			end
			hit_s1         <= 1'b0;
			c_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			hit_s1 <= hit;
			if (accept) begin
				c_q <= '0;
				unique case (item.opcode)
					OP_START: if (vok) active_q[vidx] <= 1'b0;
					OP_STOP:  if (vok) active_q[vidx] <= 1'b0;
					default: ;
				endcase
			end
			if (state_q == ST_DIV && div_stat.done) begin
				active_q[vstart_q] <= 1'b1;
			end
			if (state_q == ST_MIX) begin
				c_q <= c_q + 1'b1;
				if (cur_act && !hit) begin
					active_q[c_q] <= 1'b0;
				end
			end
			if (state_q == ST_DONE && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// voice payload, sums and result
	always_ff @(posedge clk) begin
		vsel_s1 <= c_q;
		if (accept) begin
			res_q  <= msm_out_t'({32'd0, query_hit, 1'b0});
			lsum_q <= '0;
			rsum_q <= '0;
			unique case (item.opcode)
				OP_START: begin
					if (start_go) begin
						vstart_q      <= vidx;
						base_q[vidx]  <= item.mem_address;
						len_q[vidx]   <= item.play_length;
						pos_q[vidx]   <= '0;
						lgain_q[vidx] <= gain_of(item.volume, 8'hFF - item.separation);
						rgain_q[vidx] <= gain_of(item.volume, item.separation);
					end
				end
				OP_VOLPAN: begin
					if (vok) begin
						lgain_q[vidx] <= gain_of(item.volume, 8'hFF - item.separation);
						rgain_q[vidx] <= gain_of(item.volume, item.separation);
					end
				end
				default: ;
			endcase
		end
		if (state_q == ST_DIV && div_stat.done) begin
			step_q[vstart_q] <= (div_quo > DIV_BITS'(STEP_MAX)) ?
				STEP_W'(STEP_MAX) : div_quo[STEP_W-1:0];
			res_q.start_accepted <= 1'b1;
		end
		if (hit) begin
			pos_q[c_q] <= pos_next[32] ? 32'hFFFF_FFFF : pos_next[31:0];
		end
		if (hit_s1) begin
			lsum_q <= lsum_q + lterm;
			rsum_q <= rsum_q + rterm;
		end
		if (state_q == ST_WB) begin
			res_q.left_out  <= lsum_q;
			res_q.right_out <= rsum_q;
		end
		if (state_q == ST_DONE && (!result_valid_q || result_ready)) begin
			result_q <= res_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the start sequence");

	a_hit_in_mix: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> (state_q == ST_MIX || state_q == ST_DRAIN))
		else $error("accumulate beat outside a mix frame");

	a_reject_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.opcode == OP_START && item.play_length == 16'd0)
		|=> (state_q == ST_DONE && !res_q.start_accepted))
		else $error("zero length start not rejected");

	a_wb_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB |=> state_q == ST_DONE && res_q.left_out == $past(lsum_q))
		else $error("mix sums not written back");
`endif

endmodule

// File: test/multichannel_sample_mixer_test.sv
module multichannel_sample_mixer_test;
	import msm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int TOTAL_ITEMS = 1450;
	localparam int IDLE_PCT = 23;

	class mixer_scoreboard;
		logic [7:0] mem [MEM_DEPTH];
		bit written [MEM_DEPTH];
		bit active [VOICES];
		logic [15:0] base [VOICES];
		logic [15:0] len [VOICES];
		logic [31:0] pos [VOICES];
		logic [STEP_W-1:0] step [VOICES];
		logic [6:0] lgain [VOICES];
		logic [6:0] rgain [VOICES];
		msm_out_t results_due [$];
		int errors;

		function new();
			for (int c = 0; c < VOICES; c++) begin
				active[c] = 0;
				base[c] = '0;
				len[c] = '0;
				pos[c] = '0;
				step[c] = '0;
				lgain[c] = '0;
				rgain[c] = '0;
			end
			errors = 0;
		endfunction

		function void set_gain(int c, logic [6:0] vol, logic [7:0] sep);
			lgain[c] = 7'((int'(vol) * (255 - int'(sep))) / 255);
			rgain[c] = 7'((int'(vol) * int'(sep)) / 255);
		endfunction

		function void note_item(msm_in_t it);
			msm_out_t r;
			int v;
			longint rate;
			longint st;
			int smp;
			logic [15:0] a;
			logic [32:0] np;
			r = '0;
			v = int'(it.voice);
			case (it.opcode)
				OP_WRITE: begin
					mem[it.mem_address] = it.sample_byte;
					written[it.mem_address] = 1;
				end
				OP_START: begin
					if (v < VOICES) begin
						active[v] = 0;
						if (it.play_length != 0) begin
							rate = longint'(it.source_rate);
							if (rate == 0)
								rate = OUTPUT_RATE;
							st = (rate << 16) / OUTPUT_RATE;
							if (st > STEP_MAX)
								st = STEP_MAX;
							base[v] = it.mem_address;
							len[v] = it.play_length;
							pos[v] = '0;
							step[v] = STEP_W'(st);
							set_gain(v, it.volume, it.separation);
							active[v] = 1;
							r.start_accepted = 1'b1;
						end
					end
				end
				OP_STOP: begin
					if (v < VOICES)
						active[v] = 0;
				end
				OP_VOLPAN: begin
					if (v < VOICES)
						set_gain(v, it.volume, it.separation);
				end
				OP_MIX: begin
					for (int c = 0; c < VOICES; c++) begin
						if (!active[c])
							continue;
						if (pos[c][31:16] >= len[c]) begin
							active[c] = 0;
							continue;
						end
						a = base[c] + pos[c][31:16];
						smp = (int'(mem[a]) - 128) * 256;
						r.left_out = r.left_out + 16'((smp * int'(lgain[c])) >>> 7);
						r.right_out = r.right_out + 16'((smp * int'(rgain[c])) >>> 7);
						np = {1'b0, pos[c]} + 33'(step[c]);
						pos[c] = np[32] ? '1 : np[31:0];
					end
				end
				OP_QUERY: begin
					r.voice_playing = (v < VOICES) && active[v];
				end
				default: ;
			endcase
			results_due.push_back(r);
		endfunction

		function void check_result(msm_out_t got);
			msm_out_t want;
			if (results_due.size() == 0) begin
				$error("result beat with nothing outstanding: %p", got);
				errors++;
				return;
			end
			want = results_due.pop_front();
			if (got.left_out !== want.left_out) begin
				$error("left_out expected %0d actual %0d", want.left_out, got.left_out);
				errors++;
			end
			if (got.right_out !== want.right_out) begin
				$error("right_out expected %0d actual %0d", want.right_out, got.right_out);
				errors++;
			end
			if (got.voice_playing !== want.voice_playing) begin
				$error("voice_playing expected %0b actual %0b",
					want.voice_playing, got.voice_playing);
				errors++;
			end
			if (got.start_accepted !== want.start_accepted) begin
				$error("start_accepted expected %0b actual %0b",
					want.start_accepted, got.start_accepted);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	msm_in_t item;
	logic result_valid;
	logic result_ready;
	msm_out_t result;

	mixer_scoreboard sb;
	bit calm;
	int sent;

	multichannel_sample_mixer DUT (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result
	);

	always #1 clk = ~clk;

	function automatic msm_in_t compose(logic [2:0] op, int v, int addr, int smp, int plen,
		int rate, int vol, int sep);
		msm_in_t it;
		it.opcode = op;
		it.voice = 3'(v);
		it.mem_address = 16'(addr);
		it.sample_byte = 8'(smp);
		it.play_length = 16'(plen);
		it.source_rate = 16'(rate);
		it.volume = 7'(vol);
		it.separation = 8'(sep);
		return it;
	endfunction

	function automatic logic [7:0] sample_value();
		int k;
		k = $urandom_range(0, 99);
		if (k < 10)
			return 8'd0;
		if (k < 20)
			return 8'd255;
		if (k < 25)
			return 8'd128;
		return 8'($urandom);
	endfunction

	// address of a byte the next frame reads that holds nothing yet, or -1
	function automatic int unwritten_read();
		logic [15:0] a;
		for (int c = 0; c < VOICES; c++) begin
			if (sb.active[c] && sb.pos[c][31:16] < sb.len[c]) begin
				a = sb.base[c] + sb.pos[c][31:16];
				if (!sb.written[a])
					return int'(a);
			end
		end
		return -1;
	endfunction

	task automatic drive_beat(msm_in_t it);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_item(it);
		sent++;
	endtask

	task automatic send_item(msm_in_t it);
		msm_in_t fix;
		int a;
		if (it.opcode == OP_MIX) begin
			a = unwritten_read();
			while (a >= 0) begin
				fix = it;
				fix.opcode = OP_WRITE;
				fix.mem_address = 16'(a);
				fix.sample_byte = sample_value();
				drive_beat(fix);
				a = unwritten_read();
			end
		end
		drive_beat(it);
	endtask

	function automatic msm_in_t random_item();
		msm_in_t it;
		int k;
		int live [$];
		int c;
		it = compose(OP_MIX, $urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		k = $urandom_range(0, 99);
		if (k < 10) begin
			it.opcode = OP_WRITE;
			it.sample_byte = sample_value();
		end else if (k < 14) begin
			it.opcode = OP_WRITE;
			it.sample_byte = sample_value();
			for (int i = 0; i < VOICES; i++)
				if (sb.active[i])
					live.push_back(i);
			if (live.size() != 0) begin
				c = live[$urandom_range(0, live.size() - 1)];
				it.mem_address = sb.base[c] + sb.pos[c][31:16];
			end
		end else if (k < 28) begin
			it.opcode = OP_START;
			k = $urandom_range(0, 99);
			if (k < 5)
				it.play_length = '0;
			else if (k < 60)
				it.play_length = 16'($urandom_range(1, 48));
			else if (k < 90)
				it.play_length = 16'($urandom_range(1, 600));
			k = $urandom_range(0, 99);
			if (k < 40)
				it.source_rate = 16'($urandom_range(0, 4000));
			else if (k < 55)
				it.source_rate = '0;
			else if (k < 70)
				it.source_rate = 16'(OUTPUT_RATE);
			if ($urandom_range(0, 9) == 0)
				it.volume = $urandom_range(0, 1) ? 7'd127 : 7'd0;
			if ($urandom_range(0, 9) == 0)
				it.separation = $urandom_range(0, 1) ? 8'd255 : 8'd0;
		end else if (k < 32) begin
			it.opcode = OP_STOP;
		end else if (k < 40) begin
			it.opcode = OP_VOLPAN;
		end else if (k < 50) begin
			it.opcode = OP_QUERY;
		end else if (k < 53) begin
			it.opcode = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
		end
		return it;
	endfunction

	task automatic run_directed();
		send_item(compose(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_MIX, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_WRITE, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_WRITE, 0, 65535, 255, 0, 0, 0, 0));
		send_item(compose(OP_WRITE, 0, 1, 128, 0, 0, 0, 0));
		send_item(compose(OP_WRITE, 0, 2, 255, 0, 0, 0, 0));
		send_item(compose(OP_START, 0, 0, 0, 3, OUTPUT_RATE, 127, 0));
		// base at the top of memory, reads wrap to address zero
		send_item(compose(OP_START, 1, 65535, 0, 2, 0, 127, 255));
		send_item(compose(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_MIX, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_MIX, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_VOLPAN, 0, 0, 0, 0, 0, 0, 128));
		// zero length, start refused
		send_item(compose(OP_START, 2, 65535, 255, 0, 65535, 127, 255));
		send_item(compose(OP_QUERY, 2, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_START, 3, 2, 0, 1, 1, 127, 128));
		send_item(compose(OP_MIX, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_MIX, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
		// restart of a playing voice
		send_item(compose(OP_START, 3, 0, 0, 2, 22050, 100, 200));
		send_item(compose(OP_MIX, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_STOP, 3, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_QUERY, 3, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_SPARE_LO, 0, 0, 0, 0, 0, 0, 0));
		send_item(compose(OP_SPARE_HI, 7, 65535, 255, 65535, 65535, 127, 255));
		send_item(compose(OP_MIX, 0, 0, 0, 0, 0, 0, 0));
	endtask

	initial begin
		sb = new();
		calm = 0;
		sent = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (sent < TOTAL_ITEMS) begin
			calm = (sent >= 500 && sent < 800);
			send_item(random_item());
		end
		calm = 0;
		item_valid <= 1'b0;
		while (sb.results_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// result side: random back-pressure, every accepted beat checked
	initial begin
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				sb.check_result(result);
			result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
